### hdl/dpg_pkg.sv
// shared types and constants of the dense projection block
package dpg_pkg;

  localparam int DATA_W  = 16;
  localparam int BIAS_W  = 32;
  localparam int ACC_W   = 48;
  localparam int ROW_W   = 12;
  localparam int ADDR_W  = 16;
  localparam int CCOL_W  = 11;
  localparam int CROW_W  = 13;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_WEIGHT = 1'b1;

  localparam logic [CIDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BIAS_ENABLE  = 2'd2;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] element;
    logic signed [BIAS_W-1:0] bias_value;
  } dpg_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] row_sum;
    logic [ROW_W-1:0]        row_index;
    logic                    last_row;
  } dpg_result_t;

  // classified command passed from front to back
  typedef struct packed {
    logic                     is_weight;
    logic                     first;
    logic                     last;
    logic                     last_row;
    logic signed [DATA_W-1:0] element;
    logic signed [ACC_W-1:0]  bias;
    logic [ADDR_W-1:0]        addr;
    logic [ROW_W-1:0]         row;
  } dpg_cmd_t;

endpackage

### hdl/dpg_front.sv
// front end: accepts words, tracks positions and classifies them into commands
module dpg_front #(
  parameter int CW = 11,
  parameter int RW = 13
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dpg_pkg::dpg_item_t item,
  input  logic [CW-1:0]     cols,
  input  logic [RW-1:0]     rows,
  input  logic              bias_enable,
  input  logic              full,
  output logic              busy,
  output logic              push,
  output dpg_pkg::dpg_cmd_t push_cmd
);
  import dpg_pkg::*;

  logic [CW-1:0] load_pos;
  logic [CW-1:0] col_pos;
  logic [RW-1:0] row_pos;
  logic [CW-1:0] lp, lp_inc, cp, cp_inc;
  logic [RW-1:0] rp, rp_inc;
  logic          is_weight, col_last, row_last;

  assign busy      = full;
  assign push      = start & ~full;
  assign is_weight = (item.opcode == OP_WEIGHT);

  // positions left stale by a count change restart at zero
  assign lp     = (load_pos >= cols) ? '0 : load_pos;
  assign cp     = (col_pos >= cols) ? '0 : col_pos;
  assign rp     = (row_pos >= rows) ? '0 : row_pos;
  assign lp_inc = lp + CW'(1);
  assign cp_inc = cp + CW'(1);
  assign rp_inc = rp + RW'(1);
  assign col_last = (cp_inc >= cols);
  assign row_last = (rp_inc >= rows);

  always_comb begin
    push_cmd           = '0;
    push_cmd.is_weight = is_weight;
    push_cmd.element   = item.element;
    if (is_weight) begin
      push_cmd.first    = (cp == '0);
      push_cmd.last     = col_last;
      push_cmd.last_row = row_last;
      push_cmd.addr     = ADDR_W'(cp);
      push_cmd.row      = ROW_W'(rp);
      if ((cp == '0) && bias_enable) begin
        push_cmd.bias = ACC_W'(item.bias_value);
      end
    end else begin
      push_cmd.addr = ADDR_W'(lp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      col_pos  <= '0;
      row_pos  <= '0;
    end else if (push) begin
      if (is_weight) begin
        col_pos <= col_last ? '0 : cp_inc;
        if (col_last) begin
          row_pos <= row_last ? '0 : rp_inc;
        end else begin
          row_pos <= rp;
        end
      end else begin
        load_pos <= (lp_inc >= cols) ? '0 : lp_inc;
      end
    end
  end

endmodule

### hdl/dpg_queue.sv
// short command queue between front and back
module dpg_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dpg_pkg::dpg_cmd_t push_cmd,
  output logic              full,
  output logic              pop_valid,
  output dpg_pkg::dpg_cmd_t pop_cmd
);
  import dpg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  dpg_cmd_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            do_push;

  assign full      = (count == NW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push & ~full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // the back end drains one word every cycle while the queue holds any
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_valid) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !pop_valid) begin
        count <= count + NW'(1);
      end else if (!do_push && pop_valid) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

### hdl/dpg_back.sv
// back end: vector memory, multiply and row accumulation
module dpg_back #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  input  dpg_pkg::dpg_cmd_t   pop_cmd,
  output logic                result_strobe,
  output dpg_pkg::dpg_result_t result
);
  import dpg_pkg::*;

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [DATA_W-1:0]          vec_mem [MAX_COLUMNS];
  logic signed [DATA_W-1:0]   rd_data;

  // stage 1: memory read
  logic                       v1, first1, last1, last_row1;
  logic signed [DATA_W-1:0]   w1;
  logic signed [ACC_W-1:0]    bias1;
  logic [ROW_W-1:0]           row1;

  // stage 2: product
  logic                       v2, first2, last2, last_row2;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    bias2;
  logic [ROW_W-1:0]           row2;

  // stage 3: accumulate
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;

  always_ff @(posedge clk) begin
    if (pop_valid && !pop_cmd.is_weight) begin
      vec_mem[pop_cmd.addr[AW-1:0]] <= pop_cmd.element;
    end
    rd_data <= vec_mem[pop_cmd.addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    w1        <= pop_cmd.element;
    bias1     <= pop_cmd.bias;
    first1    <= pop_cmd.first;
    last1     <= pop_cmd.last;
    last_row1 <= pop_cmd.last_row;
    row1      <= pop_cmd.row;
    prod      <= w1 * rd_data;
    bias2     <= bias1;
    first2    <= first1;
    last2     <= last1;
    last_row2 <= last_row1;
    row2      <= row1;
  end

  assign acc_next = (first2 ? bias2 : acc) + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      acc           <= '0;
      result_strobe <= 1'b0;
    end else begin
      v1            <= pop_valid & pop_cmd.is_weight;
      v2            <= v1;
      result_strobe <= v2 & last2;
      if (v2) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && last2) begin
      result.row_sum   <= acc_next;
      result.row_index <= row2;
      result.last_row  <= last_row2;
    end
  end

endmodule

### hdl/dense_projection_gemv.sv
// dense projection y = W x + b, Q8.8 inputs, exact 48-bit Q32.16 row sums
// channels: command words in on start/busy (taken when start is high and busy
//   low); configuration writes on cfg_valid/cfg_ready with a register index;
//   one result word per row on result/result_strobe, the strobe high for one cycle only
// a load word (opcode 0) stores the next vector element; a weight word
//   (opcode 1) multiplies against the element of its column and accumulates
// bias_value is taken at the first weight of each row when bias is enabled
// throughput: one word per cycle; the back end drains the queue every cycle,
//   so busy stays low in steady flow and rises only if the queue is full
// a row's sum passes through the queue, the memory read, the multiply and the
//   accumulate register before it shows on result
// reset: positions, accumulator and queue clear; registers go to one column,
//   one row, bias off; the vector memory holds stale data until loaded
// the receiver cannot stall, so results leave straight from the output register
module dense_projection_gemv #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  dpg_pkg::dpg_item_t             item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dpg_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [dpg_pkg::CDATA_W-1:0]    cfg_data,
  output logic                           result_strobe,
  output dpg_pkg::dpg_result_t           result
);
  import dpg_pkg::*;

  // count widths able to hold the maximum counts themselves
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int CXW = (CW > CCOL_W) ? CW : CCOL_W;
  localparam int RXW = (RW > CROW_W) ? RW : CROW_W;

  // configuration registers
  logic [CCOL_W-1:0] column_count;
  logic [CROW_W-1:0] row_count;
  logic              bias_enable;

  // counts clamped to one .. maximum
  logic [CXW-1:0]    cols_ext;
  logic [RXW-1:0]    rows_ext;
  logic [CW-1:0]     cols;
  logic [RW-1:0]     rows;

  // front to queue to back
  logic              push;
  dpg_cmd_t          push_cmd;
  logic              full;
  logic              pop_valid;
  dpg_cmd_t          pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= CCOL_W'(1);
      row_count    <= CROW_W'(1);
      bias_enable  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT: column_count <= cfg_data[CCOL_W-1:0];
        REG_ROW_COUNT:    row_count    <= cfg_data[CROW_W-1:0];
        REG_BIAS_ENABLE:  bias_enable  <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  assign cols_ext = CXW'(column_count);
  assign rows_ext = RXW'(row_count);

  // zero counts act as one, oversized counts as the maximum
  always_comb begin
    if (cols_ext == '0) begin
      cols = CW'(1);
    end else if (cols_ext > CXW'(MAX_COLUMNS)) begin
      cols = CW'(MAX_COLUMNS);
    end else begin
      cols = cols_ext[CW-1:0];
    end
    if (rows_ext == '0) begin
      rows = RW'(1);
    end else if (rows_ext > RXW'(MAX_ROWS)) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = rows_ext[RW-1:0];
    end
  end

  dpg_front #(
    .CW (CW),
    .RW (RW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .cols        (cols),
    .rows        (rows),
    .bias_enable (bias_enable),
    .full        (full),
    .busy        (busy),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  dpg_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  dpg_back #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_cmd       (pop_cmd),
    .result_strobe (result_strobe),
    .result        (result)
  );

`ifndef SYNTH
  // every result traces back to a row-ending weight leaving the queue
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(pop_valid && pop_cmd.is_weight && pop_cmd.last, 3))
    else $error("result without a row-ending weight");

  // a queued weight that ends its row also starts it only for single-column rows
  a_first_last: assert property (@(posedge clk) disable iff (rst)
    push && push_cmd.is_weight && push_cmd.first && push_cmd.last |-> cols == CW'(1))
    else $error("row both starts and ends with more than one column");

  // rows of two or more columns never yield results on consecutive cycles
  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (cols != CW'(1)) && $stable(cols) |=> !result_strobe)
    else $error("back-to-back results with multi-column rows");
`endif

endmodule
